### src/sorted_key_offset_index_unit_assert.svh
// Assertion macros shared by the sorted key offset index unit.
`ifndef SORTED_KEY_OFFSET_INDEX_UNIT_ASSERT_SVH
`define SORTED_KEY_OFFSET_INDEX_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define SKOI_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

`define SKOI_ASSERT_IMPLIES(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

`else

`define SKOI_ASSERT_ALWAYS(lbl, expr, msg)

`define SKOI_ASSERT_IMPLIES(lbl, cond, expr, msg)

`endif

`endif

### src/skoi_pkg.sv
`timescale 1ns / 1ps

package skoi_pkg;

    localparam int KEY_IN_BITS  = 64;
    localparam int OFFSET_BITS  = 31;
    localparam int POS_BITS     = 8;
    localparam int COUNT_BITS   = 9;
    localparam int S_TDATA_BITS = 96;
    localparam int M_TDATA_BITS = 48;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_CHK_RD,
        ST_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    probe_rd;
        logic    probe_cmp;
        logic    chk_rd;
        logic    ptr_init_ins;
        logic    ptr_init_del;
        logic    shift_rd;
        logic    shift_wr;
        logic    ins_wr;
        logic    count_inc;
        logic    count_dec;
        logic    set_result;
        status_t res_code;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  range_empty;
        logic  lo_lt_count;
        logic  key_eq;
        logic  shift_more;
        logic  out_free;
    } stat_t;

endpackage

### src/sorted_key_offset_index_unit.sv
// From accept to m_axis_tvalid: mode 3, or an insert into a full table, ends without a RAM access;
// search and delete run a binary search of RAM probes; a delete of a missing key ends at most with a check read.
// Insert and delete then shift the entries above the target; each moved entry costs a RAM read and write.
// Throughput: one word at a time; the next word is accepted in the cycle after the result loads.
// A stalled result register holds the controller in its done state, so output stalls delay every operation.
// Reset: aresetn synchronous, active low; empties the table at once by clearing the entry count.
`timescale 1ns / 1ps

module sorted_key_offset_index_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BITS    = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // key [63:0], record_offset [94:64], zero [95]
    input  logic [skoi_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    // mode [1:0]
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // found_offset [30:0], position [38:31], entry_count [47:39]
    output logic [skoi_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
    // status [1:0]
    output logic [1:0]                         m_axis_tuser
);

    skoi_pkg::cmd_t  cmd;
    skoi_pkg::stat_t stat;

    logic [skoi_pkg::OFFSET_BITS-1:0] m_offset;
    logic [skoi_pkg::POS_BITS-1:0]    m_position;
    logic [skoi_pkg::COUNT_BITS-1:0]  m_count;

    skoi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    skoi_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_mode     (s_axis_tuser),
        .s_key      (s_axis_tdata[skoi_pkg::KEY_IN_BITS-1:0]),
        .s_offset   (s_axis_tdata[skoi_pkg::KEY_IN_BITS+skoi_pkg::OFFSET_BITS-1:
                                  skoi_pkg::KEY_IN_BITS]),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_status   (m_axis_tuser),
        .m_offset   (m_offset),
        .m_position (m_position),
        .m_count    (m_count)
    );

    assign m_axis_tdata = {m_count, m_position, m_offset};

endmodule

### src/skoi_ram.sv
`timescale 1ns / 1ps

module skoi_ram #(
    parameter int WIDTH = 95,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/skoi_ctrl.sv
`timescale 1ns / 1ps
`include "sorted_key_offset_index_unit_assert.svh"

module skoi_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  skoi_pkg::stat_t  stat,
    output skoi_pkg::cmd_t   cmd
);

    skoi_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skoi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = skoi_pkg::STAT_OK;
        s_ready      = 1'b0;
        unique case (state_reg)
            skoi_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = skoi_pkg::ST_START;
                end
            end
            skoi_pkg::ST_START: begin
                unique case (stat.mode)
                    skoi_pkg::MODE_NOP: begin
                        cmd.set_result = 1'b1;
                        cmd.res_code   = skoi_pkg::STAT_NOT_FOUND;
                        state_next     = skoi_pkg::ST_DONE;
                    end
                    skoi_pkg::MODE_INSERT: begin
                        if (stat.full) begin
                            cmd.set_result = 1'b1;
                            cmd.res_code   = skoi_pkg::STAT_FULL;
                            state_next     = skoi_pkg::ST_DONE;
                        end else begin
                            state_next = skoi_pkg::ST_PROBE_RD;
                        end
                    end
                    skoi_pkg::MODE_DELETE, skoi_pkg::MODE_SEARCH: begin
                        state_next = skoi_pkg::ST_PROBE_RD;
                    end
                endcase
            end
            skoi_pkg::ST_PROBE_RD: begin
                if (!stat.range_empty) begin
                    cmd.probe_rd = 1'b1;
                    state_next   = skoi_pkg::ST_PROBE_CMP;
                end else begin
                    unique case (stat.mode)
                        skoi_pkg::MODE_INSERT: begin
                            cmd.ptr_init_ins = 1'b1;
                            state_next       = skoi_pkg::ST_SHIFT_RD;
                        end
                        skoi_pkg::MODE_DELETE: begin
                            if (stat.lo_lt_count) begin
                                state_next = skoi_pkg::ST_CHK_RD;
                            end else begin
                                cmd.set_result = 1'b1;
                                cmd.res_code   = skoi_pkg::STAT_NOT_FOUND;
                                state_next     = skoi_pkg::ST_DONE;
                            end
                        end
                        skoi_pkg::MODE_SEARCH, skoi_pkg::MODE_NOP: begin
                            cmd.set_result = 1'b1;
                            cmd.res_code   = skoi_pkg::STAT_NOT_FOUND;
                            state_next     = skoi_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            skoi_pkg::ST_PROBE_CMP: begin
                cmd.probe_cmp = 1'b1;
                if (stat.mode == skoi_pkg::MODE_SEARCH && stat.key_eq) begin
                    state_next = skoi_pkg::ST_DONE;
                end else begin
                    state_next = skoi_pkg::ST_PROBE_RD;
                end
            end
            skoi_pkg::ST_CHK_RD: begin
                cmd.chk_rd = 1'b1;
                state_next = skoi_pkg::ST_CHK;
            end
            skoi_pkg::ST_CHK: begin
                if (stat.key_eq) begin
                    cmd.ptr_init_del = 1'b1;
                    state_next       = skoi_pkg::ST_SHIFT_RD;
                end else begin
                    cmd.set_result = 1'b1;
                    cmd.res_code   = skoi_pkg::STAT_NOT_FOUND;
                    state_next     = skoi_pkg::ST_DONE;
                end
            end
            skoi_pkg::ST_SHIFT_RD: begin
                if (stat.shift_more) begin
                    cmd.shift_rd = 1'b1;
                    state_next   = skoi_pkg::ST_SHIFT_WR;
                end else begin
                    cmd.set_result = 1'b1;
                    cmd.res_code   = skoi_pkg::STAT_OK;
                    if (stat.mode == skoi_pkg::MODE_INSERT) begin
                        cmd.ins_wr    = 1'b1;
                        cmd.count_inc = 1'b1;
                    end else begin
                        cmd.count_dec = 1'b1;
                    end
                    state_next = skoi_pkg::ST_DONE;
                end
            end
            skoi_pkg::ST_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = skoi_pkg::ST_SHIFT_RD;
            end
            skoi_pkg::ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = skoi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = skoi_pkg::ST_IDLE;
            end
        endcase
    end

    `SKOI_ASSERT_IMPLIES(a_wr_after_rd, state_reg == skoi_pkg::ST_SHIFT_WR, $past(state_reg == skoi_pkg::ST_SHIFT_RD), "shift write without read")

endmodule

### src/skoi_datapath.sv
`timescale 1ns / 1ps
`include "sorted_key_offset_index_unit_assert.svh"

module skoi_datapath #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BITS    = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  skoi_pkg::cmd_t                    cmd,
    output skoi_pkg::stat_t                   stat,
    input  logic [1:0]                        s_mode,
    input  logic [skoi_pkg::KEY_IN_BITS-1:0]  s_key,
    input  logic [skoi_pkg::OFFSET_BITS-1:0]  s_offset,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [skoi_pkg::OFFSET_BITS-1:0]  m_offset,
    output logic [skoi_pkg::POS_BITS-1:0]     m_position,
    output logic [skoi_pkg::COUNT_BITS-1:0]   m_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = KEY_BITS + skoi_pkg::OFFSET_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    skoi_pkg::mode_t                mode_reg;
    logic [KEY_BITS-1:0]            key_reg;
    logic [skoi_pkg::OFFSET_BITS-1:0] offs_reg;
    logic [CW-1:0]                  lo_reg, lo_next;
    logic [CW-1:0]                  hi_reg, hi_next;
    logic [CW-1:0]                  ptr_reg;
    logic [CW-1:0]                  count_reg, count_next;

    skoi_pkg::status_t              res_status_reg;
    logic [skoi_pkg::OFFSET_BITS-1:0] res_offs_reg;
    logic [AW-1:0]                  res_pos_reg;

    logic                           out_valid_reg;
    skoi_pkg::status_t              out_status_reg;
    logic [skoi_pkg::OFFSET_BITS-1:0] out_offs_reg;
    logic [skoi_pkg::POS_BITS-1:0]  out_pos_reg;
    logic [skoi_pkg::COUNT_BITS-1:0] out_count_reg;

    logic [CW-1:0]                  span_m1;
    logic [CW-1:0]                  mid_w;
    logic [CW-1:0]                  mid_p1;
    logic [CW-1:0]                  ptr_m1;
    logic [CW-1:0]                  ptr_p1;
    logic [RW-1:0]                  rdata;
    logic [KEY_BITS-1:0]            rkey;
    logic                           key_eq;
    logic                           key_gt;
    logic                           ram_we;
    logic                           ram_re;
    logic [AW-1:0]                  ram_waddr;
    logic [AW-1:0]                  ram_raddr;
    logic [RW-1:0]                  ram_wdata;
    logic [AW+skoi_pkg::POS_BITS-1:0]   pos_wide;
    logic [CW+skoi_pkg::COUNT_BITS-1:0] count_wide;

    assign span_m1 = hi_reg - lo_reg - ONE_C;
    assign mid_w   = lo_reg + (span_m1 >> 1);
    assign mid_p1  = mid_w + ONE_C;
    assign ptr_m1  = ptr_reg - ONE_C;
    assign ptr_p1  = ptr_reg + ONE_C;

    assign rkey   = rdata[KEY_BITS-1:0];
    assign key_eq = (rkey == key_reg);
    assign key_gt = (rkey > key_reg);

    always_comb begin
        ram_re    = cmd.probe_rd | cmd.chk_rd | cmd.shift_rd;
        ram_raddr = mid_w[AW-1:0];
        if (cmd.chk_rd) begin
            ram_raddr = lo_reg[AW-1:0];
        end else if (cmd.shift_rd) begin
            ram_raddr = (mode_reg == skoi_pkg::MODE_INSERT) ? ptr_m1[AW-1:0] : ptr_p1[AW-1:0];
        end
        ram_we    = cmd.ins_wr | cmd.shift_wr;
        ram_waddr = cmd.ins_wr ? lo_reg[AW-1:0] : ptr_reg[AW-1:0];
        ram_wdata = cmd.ins_wr ? {offs_reg, key_reg} : rdata;
    end

    skoi_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.load) begin
            lo_next = '0;
            hi_next = count_reg;
        end else if (cmd.probe_cmp) begin
            if (key_gt || (mode_reg == skoi_pkg::MODE_DELETE && key_eq)) begin
                hi_next = mid_w;
            end else begin
                lo_next = mid_p1;
            end
        end
        count_next = count_reg;
        if (cmd.count_inc) begin
            count_next = count_reg + ONE_C;
        end else if (cmd.count_dec) begin
            count_next = count_reg - ONE_C;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg        <= '0;
            hi_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            count_reg <= count_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= skoi_pkg::mode_t'(s_mode);
            key_reg  <= s_key[KEY_BITS-1:0];
            offs_reg <= s_offset;
        end
        if (cmd.ptr_init_ins) begin
            ptr_reg <= count_reg;
        end else if (cmd.ptr_init_del) begin
            ptr_reg <= lo_reg;
        end else if (cmd.shift_wr) begin
            ptr_reg <= (mode_reg == skoi_pkg::MODE_INSERT) ? ptr_m1 : ptr_p1;
        end
        if (cmd.probe_cmp && mode_reg == skoi_pkg::MODE_SEARCH && key_eq) begin
            res_status_reg <= skoi_pkg::STAT_OK;
            res_offs_reg   <= rdata[RW-1:KEY_BITS];
            res_pos_reg    <= mid_w[AW-1:0];
        end else if (cmd.set_result) begin
            res_status_reg <= cmd.res_code;
            res_offs_reg   <= '0;
            res_pos_reg    <= (cmd.res_code == skoi_pkg::STAT_OK) ? lo_reg[AW-1:0] : '0;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_offs_reg   <= res_offs_reg;
            out_pos_reg    <= pos_wide[skoi_pkg::POS_BITS-1:0];
            out_count_reg  <= count_wide[skoi_pkg::COUNT_BITS-1:0];
        end
    end

    assign pos_wide   = {{skoi_pkg::POS_BITS{1'b0}}, res_pos_reg};
    assign count_wide = {{skoi_pkg::COUNT_BITS{1'b0}}, count_reg};

    always_comb begin
        stat.mode        = mode_reg;
        stat.full        = (count_reg == DEPTH_C);
        stat.range_empty = (lo_reg >= hi_reg);
        stat.lo_lt_count = (lo_reg < count_reg);
        stat.key_eq      = key_eq;
        stat.shift_more  = (mode_reg == skoi_pkg::MODE_INSERT) ? (ptr_reg > lo_reg)
                                                                : (ptr_p1 < count_reg);
        stat.out_free    = !out_valid_reg || m_ready;
    end

    assign m_valid    = out_valid_reg;
    assign m_status   = out_status_reg;
    assign m_offset   = out_offs_reg;
    assign m_position = out_pos_reg;
    assign m_count    = out_count_reg;

    `SKOI_ASSERT_ALWAYS(a_count_range, count_reg <= DEPTH_C, "entry count exceeds depth")
    `SKOI_ASSERT_ALWAYS(a_bounds_order, lo_reg <= hi_reg, "search bounds crossed")
    `SKOI_ASSERT_IMPLIES(a_ins_target, cmd.ins_wr, (lo_reg <= count_reg) && (count_reg < DEPTH_C), "insert outside occupied range")

endmodule
